### hw/rtl/sg2d_pkg.sv
// Package for the squared gradient block: shared widths, register and
// operation codes, and the result tag that travels down the cell chain.
// No dependencies; the files that use it refer to it by scoped names.
package sg2d_pkg;

  localparam int ENERGY_W     = 37;
  localparam int COL_W        = 10;
  localparam int ROW_W        = 16;
  localparam int FW_W         = 11;
  localparam int FH_W         = 16;
  localparam int CC_W         = 3;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int MAX_CHANNELS = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH   = 2'd0,
    CFG_FRAME_HEIGHT  = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  // Tag of one result: where it sits in the frame.
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             done;
  } res_meta_t;

endpackage

### hw/rtl/sg2d_in_if.sv
// Pixel channel: valid/ready handshake with the operation and four samples.
// Does not depend on sg2d_pkg.
interface sg2d_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic signed [SAMPLE_BITS-1:0] sample_a;
  logic signed [SAMPLE_BITS-1:0] sample_b;
  logic signed [SAMPLE_BITS-1:0] sample_c;
  logic signed [SAMPLE_BITS-1:0] sample_d;

  modport source (output valid, operation, sample_a, sample_b, sample_c, sample_d,
                  input ready);
  modport sink   (input valid, operation, sample_a, sample_b, sample_c, sample_d,
                  output ready);
endinterface

### hw/rtl/sg2d_out_if.sv
// Result channel: valid/ready handshake with the energy and its position.
// Widths come from sg2d_pkg.
interface sg2d_out_if;
  logic                              valid;
  logic                              ready;
  logic [sg2d_pkg::ENERGY_W-1:0]     gradient_energy;
  logic [sg2d_pkg::COL_W-1:0]        pixel_col;
  logic [sg2d_pkg::ROW_W-1:0]        pixel_row;
  logic                              frame_done;

  modport source (output valid, gradient_energy, pixel_col, pixel_row, frame_done,
                  input ready);
  modport sink   (input valid, gradient_energy, pixel_col, pixel_row, frame_done,
                  output ready);
endinterface

### hw/rtl/sg2d_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module sg2d_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

### hw/rtl/sg2d_cell.sv
// One cell of the summing chain: squares the two derivatives of its own
// channel, adds them to the running sum and hands everything on.
// Depends on sg2d_pkg.
module sg2d_cell #(
  parameter int CHANNELS = 4,
  parameter int DIFF_W   = 18,
  parameter int INDEX    = 0
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [sg2d_pkg::ENERGY_W-1:0]   in_sum,
  input  logic signed [DIFF_W-1:0]        in_dx [CHANNELS],
  input  logic signed [DIFF_W-1:0]        in_dy [CHANNELS],
  input  sg2d_pkg::res_meta_t             in_meta,
  output logic                            out_valid,
  output logic [sg2d_pkg::ENERGY_W-1:0]   out_sum,
  output logic signed [DIFF_W-1:0]        out_dx [CHANNELS],
  output logic signed [DIFF_W-1:0]        out_dy [CHANNELS],
  output sg2d_pkg::res_meta_t             out_meta
);

  logic signed [2*DIFF_W-1:0] sqx;
  logic signed [2*DIFF_W-1:0] sqy;

  assign sqx = (2*DIFF_W)'(in_dx[INDEX]) * (2*DIFF_W)'(in_dx[INDEX]);
  assign sqy = (2*DIFF_W)'(in_dy[INDEX]) * (2*DIFF_W)'(in_dy[INDEX]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sum  <= in_sum + sg2d_pkg::ENERGY_W'($unsigned(sqx))
                         + sg2d_pkg::ENERGY_W'($unsigned(sqy));
      out_dx   <= in_dx;
      out_dy   <= in_dy;
      out_meta <= in_meta;
    end
  end

endmodule

### hw/rtl/squared_gradient_2d.sv
// Squared gradient magnitude over a raster stream, with three line stores.
// Depends on sg2d_pkg, sg2d_in_if, sg2d_out_if, sg2d_ram and sg2d_cell.
//
// Pixels enter on the pixels channel in raster order, one per transfer; the
// result for a pixel of row y-1 is computed from the transfer of the pixel of
// row y in the same column and leaves on the results channel. After the last
// pixel of a frame the source sends one drain item per column to push out the
// final row. The block sustains one item per clock while results.ready is
// high. An input transfer passes through the line store read, the difference
// stage and one cell per channel in the summing chain, the last cell being
// the output register. The whole pipeline moves together: when the receiver
// holds results.ready low with a result waiting, pixels.ready drops in the
// same cycle and every stage holds. Reset clears the counters and pipeline
// valids and loads the register defaults (1024 by 1024, one channel); the
// line stores are not cleared and the first row of a frame only fills them.
// Configuration is written through cfg_write, cfg_index and cfg_data; the
// user must write it only while the block is idle, which it does not enforce.
module squared_gradient_2d #(
  parameter int MAX_WIDTH   = 1024,
  parameter int CHANNELS    = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  sg2d_in_if.sink                       pixels,
  sg2d_out_if.source                    results,
  input  logic                          cfg_write,
  input  logic [sg2d_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sg2d_pkg::CFG_W-1:0]    cfg_data
);

  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int CMPW   = (XW + 1 > sg2d_pkg::FW_W) ? XW + 1 : sg2d_pkg::FW_W;
  localparam int SB     = SAMPLE_BITS;
  localparam int DIFF_W = SAMPLE_BITS + 2;
  localparam int MEM_W  = CHANNELS * SAMPLE_BITS;
  localparam int RW     = sg2d_pkg::ROW_W;

  typedef enum logic [1:0] {
    DY_NONE,
    DY_CUR_ONE_SIDED,
    DY_CENTRAL,
    DY_STORED_ONE_SIDED
  } dy_mode_t;

  // Configuration registers
  logic [sg2d_pkg::FW_W-1:0] frame_width;
  logic [sg2d_pkg::FH_W-1:0] frame_height;
  logic [sg2d_pkg::CC_W-1:0] channel_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= sg2d_pkg::FW_W'(1024);
      frame_height  <= sg2d_pkg::FH_W'(1024);
      channel_count <= sg2d_pkg::CC_W'(1);
    end else if (cfg_write) begin
      unique case (sg2d_pkg::cfg_reg_t'(cfg_index))
        sg2d_pkg::CFG_FRAME_WIDTH:   frame_width   <= cfg_data[sg2d_pkg::FW_W-1:0];
        sg2d_pkg::CFG_FRAME_HEIGHT:  frame_height  <= cfg_data[sg2d_pkg::FH_W-1:0];
        sg2d_pkg::CFG_CHANNEL_COUNT: channel_count <= cfg_data[sg2d_pkg::CC_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CMPW-1:0]           w_eff;
  logic [RW-1:0]             h_eff;
  logic [sg2d_pkg::CC_W-1:0] nc_eff;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = CMPW'(1);
    end else if (CMPW'(frame_width) > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end else begin
      w_eff = CMPW'(frame_width);
    end
    h_eff = (frame_height == '0) ? RW'(1) : frame_height;
    if (channel_count == '0) begin
      nc_eff = sg2d_pkg::CC_W'(1);
    end else if (channel_count > sg2d_pkg::CC_W'(CHANNELS)) begin
      nc_eff = sg2d_pkg::CC_W'(CHANNELS);
    end else begin
      nc_eff = channel_count;
    end
  end

  // Frame position
  logic [XW-1:0] column_count, column_count_next;
  logic [RW-1:0] row_count, row_count_next;
  logic [XW-1:0] drain_count, drain_count_next;
  logic          draining, draining_next;

  logic adv, acc, is_drain, take_pix, take_drn;
  logic [XW-1:0]   x;
  logic [CMPW-1:0] x1;
  logic            x_last;
  logic [XW-1:0]   addr_r;

  assign adv      = !results.valid || results.ready;
  assign pixels.ready = adv;
  assign acc      = pixels.valid && adv;
  assign is_drain = (pixels.operation == sg2d_pkg::OP_DRAIN);
  assign take_pix = acc && !is_drain && !draining;
  assign take_drn = acc && is_drain && draining;
  assign x        = draining ? drain_count : column_count;
  assign x1       = CMPW'(x) + CMPW'(1);
  assign x_last   = (x1 >= w_eff);
  assign addr_r   = x_last ? x : XW'(x1);

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    drain_count_next  = drain_count;
    draining_next     = draining;
    if (take_pix) begin
      if (x_last) begin
        column_count_next = '0;
        if ((RW + 1)'(row_count) + (RW + 1)'(1) >= (RW + 1)'(h_eff)) begin
          draining_next    = 1'b1;
          drain_count_next = '0;
        end else begin
          row_count_next = row_count + RW'(1);
        end
      end else begin
        column_count_next = XW'(x1);
      end
    end else if (take_drn) begin
      if (x_last) begin
        draining_next     = 1'b0;
        drain_count_next  = '0;
        row_count_next    = '0;
        column_count_next = '0;
      end else begin
        drain_count_next = XW'(x1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      drain_count  <= '0;
      draining     <= 1'b0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      drain_count  <= drain_count_next;
      draining     <= draining_next;
    end
  end

  // Line stores. The previous row is kept twice so that the centre and the
  // right neighbour can be read in the same cycle.
  logic signed [SB-1:0] samp4 [sg2d_pkg::MAX_CHANNELS];
  logic [MEM_W-1:0]     cur_word;
  logic [MEM_W-1:0]     prev_c_rd, prev_r_rd, older_rd;

  assign samp4[0] = pixels.sample_a;
  assign samp4[1] = pixels.sample_b;
  assign samp4[2] = pixels.sample_c;
  assign samp4[3] = pixels.sample_d;

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      cur_word[ch*SB +: SB] = samp4[ch];
    end
  end

  // Stage one: the item as taken, aligned with the store read data.
  logic                      s1_valid, s1_live, s1_wr, s1_fwd;
  logic [XW-1:0]             s1_x;
  logic                      s1_w_one, s1_x_first, s1_x_last, s1_right_ok;
  dy_mode_t                  s1_dy_mode;
  logic [sg2d_pkg::CC_W-1:0] s1_nc;
  sg2d_pkg::res_meta_t       s1_meta;
  logic [MEM_W-1:0]          s1_cur;
  logic [MEM_W-1:0]          older_fwd;
  logic [MEM_W-1:0]          left_word;
  dy_mode_t                  dy_mode;

  always_comb begin
    if (draining) begin
      dy_mode = (row_count != '0) ? DY_STORED_ONE_SIDED : DY_NONE;
    end else if (row_count == RW'(1)) begin
      dy_mode = DY_CUR_ONE_SIDED;
    end else begin
      dy_mode = DY_CENTRAL;
    end
  end

  sg2d_ram #(.WIDTH(MEM_W), .DEPTH(MAX_WIDTH)) u_prev_c (
    .clk(clk), .we(take_pix), .waddr(x), .wdata(cur_word),
    .re(acc), .raddr(x), .rdata(prev_c_rd)
  );

  sg2d_ram #(.WIDTH(MEM_W), .DEPTH(MAX_WIDTH)) u_prev_r (
    .clk(clk), .we(take_pix), .waddr(x), .wdata(cur_word),
    .re(acc), .raddr(addr_r), .rdata(prev_r_rd)
  );

  // The older row takes the previous row's old contents once they are read.
  sg2d_ram #(.WIDTH(MEM_W), .DEPTH(MAX_WIDTH)) u_older (
    .clk(clk), .we(s1_wr && adv), .waddr(s1_x), .wdata(prev_c_rd),
    .re(acc), .raddr(x), .rdata(older_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_live  <= 1'b0;
      s1_wr    <= 1'b0;
    end else if (adv) begin
      s1_valid <= take_drn || (take_pix && row_count != '0);
      s1_live  <= take_pix || take_drn;
      s1_wr    <= take_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // A one-pixel row rereads the entry that is being written this cycle.
      s1_fwd      <= s1_wr && (s1_x == x);
      older_fwd   <= prev_c_rd;
      s1_x        <= x;
      s1_w_one    <= (w_eff == CMPW'(1));
      s1_x_first  <= (x == '0);
      s1_x_last   <= x_last;
      s1_right_ok <= !x_last;
      s1_dy_mode  <= dy_mode;
      s1_nc       <= nc_eff;
      s1_cur      <= cur_word;
      s1_meta.col <= sg2d_pkg::COL_W'(x);
      s1_meta.row <= draining ? row_count : row_count - RW'(1);
      s1_meta.done <= draining && x_last;
    end
    if (adv && s1_live) begin
      left_word <= prev_c_rd;
    end
  end

  // Stage two: per-channel derivatives, doubled where they are one-sided.
  logic signed [DIFF_W-1:0] dx_d [CHANNELS];
  logic signed [DIFF_W-1:0] dy_d [CHANNELS];
  logic signed [DIFF_W-1:0] s2_dx [CHANNELS];
  logic signed [DIFF_W-1:0] s2_dy [CHANNELS];
  logic                     s2_valid;
  sg2d_pkg::res_meta_t      s2_meta;

  always_comb begin
    logic signed [DIFF_W-1:0] c, r, l, o, u;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      c = DIFF_W'($signed(prev_c_rd[ch*SB +: SB]));
      r = s1_right_ok ? DIFF_W'($signed(prev_r_rd[ch*SB +: SB])) : c;
      l = DIFF_W'($signed(left_word[ch*SB +: SB]));
      o = s1_fwd ? DIFF_W'($signed(older_fwd[ch*SB +: SB]))
                 : DIFF_W'($signed(older_rd[ch*SB +: SB]));
      u = DIFF_W'($signed(s1_cur[ch*SB +: SB]));
      if (s1_w_one) begin
        dx_d[ch] = '0;
      end else if (s1_x_first) begin
        dx_d[ch] = (r - c) <<< 1;
      end else if (s1_x_last) begin
        dx_d[ch] = (c - l) <<< 1;
      end else begin
        dx_d[ch] = r - l;
      end
      case (s1_dy_mode)
        DY_CUR_ONE_SIDED:    dy_d[ch] = (u - c) <<< 1;
        DY_CENTRAL:          dy_d[ch] = u - o;
        DY_STORED_ONE_SIDED: dy_d[ch] = (c - o) <<< 1;
        default:             dy_d[ch] = '0;
      endcase
      if (sg2d_pkg::CC_W'(ch) >= s1_nc) begin
        dx_d[ch] = '0;
        dy_d[ch] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_dx   <= dx_d;
      s2_dy   <= dy_d;
      s2_meta <= s1_meta;
    end
  end

  // Summing chain, one cell per channel.
  logic                          v_chain   [CHANNELS+1];
  logic [sg2d_pkg::ENERGY_W-1:0] sum_chain [CHANNELS+1];
  sg2d_pkg::res_meta_t           meta_chain [CHANNELS+1];
  logic signed [DIFF_W-1:0]      dx_chain  [CHANNELS][CHANNELS];
  logic signed [DIFF_W-1:0]      dy_chain  [CHANNELS][CHANNELS];

  assign v_chain[0]    = s2_valid;
  assign sum_chain[0]  = '0;
  assign meta_chain[0] = s2_meta;
  assign dx_chain[0]   = s2_dx;
  assign dy_chain[0]   = s2_dy;

  for (genvar k = 0; k < CHANNELS; k++) begin : g_cell
    if (k < CHANNELS - 1) begin : g_mid
      sg2d_cell #(.CHANNELS(CHANNELS), .DIFF_W(DIFF_W), .INDEX(k)) u_cell (
        .clk(clk), .rst(rst), .en(adv),
        .in_valid(v_chain[k]), .in_sum(sum_chain[k]),
        .in_dx(dx_chain[k]), .in_dy(dy_chain[k]), .in_meta(meta_chain[k]),
        .out_valid(v_chain[k+1]), .out_sum(sum_chain[k+1]),
        .out_dx(dx_chain[k+1]), .out_dy(dy_chain[k+1]), .out_meta(meta_chain[k+1])
      );
    end else begin : g_last
      sg2d_cell #(.CHANNELS(CHANNELS), .DIFF_W(DIFF_W), .INDEX(k)) u_cell (
        .clk(clk), .rst(rst), .en(adv),
        .in_valid(v_chain[k]), .in_sum(sum_chain[k]),
        .in_dx(dx_chain[k]), .in_dy(dy_chain[k]), .in_meta(meta_chain[k]),
        .out_valid(v_chain[k+1]), .out_sum(sum_chain[k+1]),
        .out_dx(), .out_dy(), .out_meta(meta_chain[k+1])
      );
    end
  end

  assign results.valid           = v_chain[CHANNELS];
  assign results.gradient_energy = sum_chain[CHANNELS];
  assign results.pixel_col       = meta_chain[CHANNELS].col;
  assign results.pixel_row       = meta_chain[CHANNELS].row;
  assign results.frame_done      = meta_chain[CHANNELS].done;

endmodule

### hw/rtl/sg2d_checker.sv
// Port-level checks for squared_gradient_2d, attached by the bind below.
// Depends on sg2d_pkg for the row width.
module sg2d_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_done,
  input logic [sg2d_pkg::ROW_W-1:0] out_row
);

  // A result that has not been transferred stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // The block takes input whenever no result is held up.
  a_in_free: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && !out_ready) |-> in_ready)
    else $error("input refused with a free output");

  // Nothing comes out straight after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result right after reset");

  // After the last result of a frame the next result starts the top row.
  a_new_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_done |=> !out_valid || out_row == '0)
    else $error("new frame does not start on the top row");

endmodule

bind squared_gradient_2d sg2d_checker u_sg2d_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(pixels.ready),
  .out_valid(results.valid),
  .out_ready(results.ready),
  .out_done(results.frame_done),
  .out_row(results.pixel_row)
);
